### src/lzbd_pkg.sv
// ----------------------------------------------------------------------------
// lzbd_pkg
// Shared types and constants of the back-reference decompressor.
// ----------------------------------------------------------------------------
package lzbd_pkg;

  typedef enum logic [2:0] {
    PH_CTL      = 3'd0,
    PH_LIT_EXT  = 3'd1,
    PH_LIT_RUN  = 3'd2,
    PH_REF_OFS  = 3'd3,
    PH_REF_CTL2 = 3'd4,
    PH_REF_EXT  = 3'd5,
    PH_COPY     = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_LIT  = 2'd1,
    KIND_COPY = 2'd2
  } kind_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CTL_END  = 2'd1;
  localparam logic [1:0] ERR_LIT_END  = 2'd2;
  localparam logic [1:0] ERR_REF_PRE  = 2'd3;

  localparam logic [7:0] CTL_EXT1     = 8'h1D;
  localparam logic [7:0] CTL_EXT2     = 8'h1E;
  localparam logic [7:0] CTL_LIT_LIM  = 8'h20;
  localparam logic [7:0] REF_EXT2     = 8'hFE;
  localparam logic [7:0] REF_EXT4     = 8'hFF;
  localparam logic [32:0] BIAS_EXT1   = 33'h1E;
  localparam logic [32:0] BIAS_EXT2   = 33'h11E;
  localparam logic [32:0] BIAS_REF2   = 33'h102;

  // One tick's result as it travels from the front to the back.
  typedef struct packed {
    logic       consumed;
    kind_t      kind;
    logic [7:0] data;
    logic       finished;
    logic [1:0] err;
  } res_t;

endpackage

### src/lzbd_fifo.sv
// ----------------------------------------------------------------------------
// lzbd_fifo
// Small synchronous queue between the decoder front and the copy back end.
// ----------------------------------------------------------------------------
module lzbd_fifo #(
  parameter int W     = 16,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (cnt_r == (PW + 1)'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? inc(wp_r) : wp_r;
    rp_nxt  = pop ? inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + (PW + 1)'(push) - (PW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

### src/lzbd_front.sv
// ----------------------------------------------------------------------------
// lzbd_front
// Header parser and stream state: decides per tick what the back end emits.
// ----------------------------------------------------------------------------
module lzbd_front #(
  parameter int HISTORY_DEPTH = 8192,
  parameter int AW            = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic              start_req,
  input  logic              byte_valid,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic [31:0]       output_limit,
  output lzbd_pkg::res_t    res,
  output logic [AW-1:0]     raddr,
  output logic [AW-1:0]     waddr
);
  lzbd_pkg::phase_t ph_r, ph_nxt;
  logic [31:0] bw_r, bw_nxt;
  logic [7:0]  ctl_r, ctl_nxt;
  logic [31:0] ext_r, ext_nxt;
  logic [2:0]  extl_r, extl_nxt;
  logic [32:0] run_r, run_nxt;
  logic [13:0] dist_r, dist_nxt;
  logic        se_r, se_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt;

  logic        do_lit, do_ref, do_end;
  logic [32:0] cnt;
  logic [12:0] ofs;
  logic [32:0] room;
  logic [13:0] rdist;
  logic [AW:0] diff;

  always_comb begin
    ph_nxt = ph_r; bw_nxt = bw_r; ctl_nxt = ctl_r; ext_nxt = ext_r;
    extl_nxt = extl_r; run_nxt = run_r; dist_nxt = dist_r; se_nxt = se_r;
    done_nxt = done_r; err_nxt = err_r; wptr_nxt = wptr_r;
    do_lit = 1'b0; do_ref = 1'b0; do_end = 1'b0;
    cnt = '0; ofs = '0; room = '0; rdist = '0; diff = '0;
    res = '0;
    res.kind = lzbd_pkg::KIND_NONE;
    raddr = '0;

    if (start_req) begin
      ph_nxt = lzbd_pkg::PH_CTL; bw_nxt = '0; ctl_nxt = '0; ext_nxt = '0;
      extl_nxt = '0; run_nxt = '0; dist_nxt = '0; se_nxt = 1'b0;
      done_nxt = 1'b0; err_nxt = lzbd_pkg::ERR_NONE; wptr_nxt = '0;
    end
    waddr = wptr_nxt;

    if (!done_nxt && err_nxt == lzbd_pkg::ERR_NONE && bw_nxt >= output_limit) begin
      done_nxt = 1'b1;
    end

    if (!done_nxt && err_nxt == lzbd_pkg::ERR_NONE) begin
      if (ph_nxt == lzbd_pkg::PH_COPY) begin
        // The source lies dist bytes behind the write pointer, around the ring.
        diff = {1'b0, wptr_nxt} - (AW + 1)'(dist_nxt);
        raddr = diff[AW] ? AW'(diff + (AW + 1)'(HISTORY_DEPTH)) : diff[AW-1:0];
        res.kind = lzbd_pkg::KIND_COPY;
        bw_nxt = bw_nxt + 32'd1;
        run_nxt = run_nxt - 33'd1;
        wptr_nxt = (wptr_nxt == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr_nxt + 1'b1;
        do_end = (run_nxt == '0);
      end else if (ph_nxt == lzbd_pkg::PH_LIT_RUN) begin
        if (byte_valid) begin
          res.consumed = 1'b1;
          res.kind = lzbd_pkg::KIND_LIT;
          res.data = in_byte;
          bw_nxt = bw_nxt + 32'd1;
          run_nxt = run_nxt - 33'd1;
          wptr_nxt = (wptr_nxt == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr_nxt + 1'b1;
          if (in_last) se_nxt = 1'b1;
          if (run_nxt == '0) do_end = 1'b1;
          else if (in_last) err_nxt = lzbd_pkg::ERR_LIT_END;
        end
      end else if (byte_valid) begin
        res.consumed = 1'b1;
        if (in_last) se_nxt = 1'b1;
        unique case (ph_nxt)
          lzbd_pkg::PH_CTL: begin
            ctl_nxt = in_byte;
            if (in_byte < lzbd_pkg::CTL_EXT1) begin
              do_lit = 1'b1;
              cnt = 33'(in_byte) + 33'd1;
            end else if (in_byte < lzbd_pkg::CTL_LIT_LIM) begin
              ext_nxt = '0;
              extl_nxt = (in_byte == lzbd_pkg::CTL_EXT1) ? 3'd1 :
                         (in_byte == lzbd_pkg::CTL_EXT2) ? 3'd2 : 3'd4;
              ph_nxt = lzbd_pkg::PH_LIT_EXT;
            end else if (!in_byte[7] && in_byte[6:5] == 2'b01) begin
              do_ref = 1'b1;
              cnt = 33'(in_byte[1:0]);
              ofs = 13'(in_byte[4:2]);
            end else begin
              ph_nxt = lzbd_pkg::PH_REF_OFS;
            end
          end
          lzbd_pkg::PH_LIT_EXT: begin
            ext_nxt = {ext_nxt[23:0], in_byte};
            extl_nxt = extl_nxt - 3'd1;
            if (extl_nxt == '0) begin
              do_lit = 1'b1;
              cnt = 33'(ext_nxt);
              if (ctl_nxt == lzbd_pkg::CTL_EXT1) cnt = cnt + lzbd_pkg::BIAS_EXT1;
              else if (ctl_nxt == lzbd_pkg::CTL_EXT2) cnt = cnt + lzbd_pkg::BIAS_EXT2;
            end
          end
          lzbd_pkg::PH_REF_OFS: begin
            if (ctl_nxt[7]) begin
              do_ref = 1'b1;
              cnt = 33'(ctl_nxt[6:5]);
              ofs = {ctl_nxt[4:0], in_byte};
            end else if (ctl_nxt[6:5] == 2'b10) begin
              do_ref = 1'b1;
              cnt = 33'(ctl_nxt[4:0]) + 33'd4;
              ofs = 13'(in_byte);
            end else begin
              dist_nxt = {1'b0, ctl_nxt[4:0], in_byte};
              ph_nxt = lzbd_pkg::PH_REF_CTL2;
            end
          end
          lzbd_pkg::PH_REF_CTL2: begin
            if (in_byte == lzbd_pkg::REF_EXT2 || in_byte == lzbd_pkg::REF_EXT4) begin
              ctl_nxt = in_byte;
              ext_nxt = '0;
              extl_nxt = (in_byte == lzbd_pkg::REF_EXT2) ? 3'd2 : 3'd4;
              ph_nxt = lzbd_pkg::PH_REF_EXT;
            end else begin
              do_ref = 1'b1;
              cnt = 33'(in_byte) + 33'd4;
              ofs = dist_nxt[12:0];
            end
          end
          lzbd_pkg::PH_REF_EXT: begin
            ext_nxt = {ext_nxt[23:0], in_byte};
            extl_nxt = extl_nxt - 3'd1;
            if (extl_nxt == '0) begin
              do_ref = 1'b1;
              cnt = 33'(ext_nxt);
              if (ctl_nxt == lzbd_pkg::REF_EXT2) cnt = cnt + lzbd_pkg::BIAS_REF2;
              ofs = dist_nxt[12:0];
            end
          end
          default: ph_nxt = lzbd_pkg::PH_CTL;
        endcase
      end

      room = (output_limit > bw_nxt) ? 33'(output_limit - bw_nxt) : '0;
      if (do_lit) begin
        run_nxt = (cnt < room) ? cnt : room;
        if (run_nxt == '0) do_end = 1'b1;
        else if (se_nxt) err_nxt = lzbd_pkg::ERR_LIT_END;
        else ph_nxt = lzbd_pkg::PH_LIT_RUN;
      end
      if (do_ref) begin
        rdist = 14'(ofs) + 14'd1;
        dist_nxt = rdist;
        cnt = cnt + 33'd3;
        if (32'(rdist) > bw_nxt) begin
          err_nxt = lzbd_pkg::ERR_REF_PRE;
        end else begin
          run_nxt = (cnt < room) ? cnt : room;
          if (run_nxt == '0) do_end = 1'b1;
          else ph_nxt = lzbd_pkg::PH_COPY;
        end
      end
      if (do_end) begin
        ph_nxt = lzbd_pkg::PH_CTL;
        if (bw_nxt >= output_limit || se_nxt) done_nxt = 1'b1;
      end
      // A header left open when the source ends is an error.
      if (res.consumed && res.kind == lzbd_pkg::KIND_NONE &&
          err_nxt == lzbd_pkg::ERR_NONE && !done_nxt && in_last &&
          (ph_nxt == lzbd_pkg::PH_LIT_EXT || ph_nxt == lzbd_pkg::PH_REF_OFS ||
           ph_nxt == lzbd_pkg::PH_REF_CTL2 || ph_nxt == lzbd_pkg::PH_REF_EXT)) begin
        err_nxt = lzbd_pkg::ERR_CTL_END;
      end
    end

    res.finished = done_nxt;
    res.err      = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= lzbd_pkg::PH_CTL; bw_r <= '0; ctl_r <= '0; ext_r <= '0;
      extl_r <= '0; run_r <= '0; dist_r <= '0; se_r <= 1'b0;
      done_r <= 1'b0; err_r <= lzbd_pkg::ERR_NONE; wptr_r <= '0;
    end else if (acc) begin
      ph_r <= ph_nxt; bw_r <= bw_nxt; ctl_r <= ctl_nxt; ext_r <= ext_nxt;
      extl_r <= extl_nxt; run_r <= run_nxt; dist_r <= dist_nxt; se_r <= se_nxt;
      done_r <= done_nxt; err_r <= err_nxt; wptr_r <= wptr_nxt;
    end
  end

endmodule

### src/lzbd_back.sv
// ----------------------------------------------------------------------------
// lzbd_back
// History memory, byte copy and output register.
// ----------------------------------------------------------------------------
module lzbd_back #(
  parameter int HISTORY_DEPTH = 8192,
  parameter int AW            = 13
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  lzbd_pkg::res_t head_res,
  input  logic [AW-1:0]  head_raddr,
  input  logic [AW-1:0]  head_waddr,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [15:0]    out_tdata
);
  logic [7:0] hist_r [HISTORY_DEPTH];

  logic           s1_v_r, s1_v_nxt;
  lzbd_pkg::res_t s1_res_r;
  logic [AW-1:0]  s1_waddr_r;
  logic           s1_fwd_r;
  logic [7:0]     s1_fwd_data_r;
  logic [7:0]     rdata_r;
  logic           out_v_r, out_v_nxt;
  logic [15:0]    out_data_r;

  logic       s1_adv, s1_wr, hazard;
  logic [7:0] s1_byte;

  assign s1_byte = (s1_res_r.kind == lzbd_pkg::KIND_COPY) ?
                   (s1_fwd_r ? s1_fwd_data_r : rdata_r) : s1_res_r.data;
  assign s1_adv  = s1_v_r && (!out_v_r || out_tready);
  assign s1_wr   = s1_adv && (s1_res_r.kind != lzbd_pkg::KIND_NONE);
  assign pop     = head_valid && (!s1_v_r || s1_adv);
  // The byte written at the same edge as this read is not yet in memory.
  assign hazard  = s1_wr && (s1_waddr_r == head_raddr);

  assign s1_v_nxt  = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign out_v_nxt = s1_adv ? 1'b1 : (out_tready ? 1'b0 : out_v_r);

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      hist_r[s1_waddr_r] <= s1_byte;
    end
    if (pop) begin
      rdata_r       <= hist_r[head_raddr];
      s1_res_r      <= head_res;
      s1_waddr_r    <= head_waddr;
      s1_fwd_r      <= hazard;
      s1_fwd_data_r <= s1_byte;
    end
    if (s1_adv) begin
      out_data_r <= {3'b000, s1_res_r.err, s1_res_r.finished,
                     (s1_res_r.kind != lzbd_pkg::KIND_NONE) ? s1_byte : 8'h00,
                     s1_res_r.kind != lzbd_pkg::KIND_NONE, s1_res_r.consumed};
    end
  end

endmodule

### src/lz_backref_decompressor.sv
// ----------------------------------------------------------------------------
// lz_backref_decompressor
// Byte-oriented LZ decompressor with back-references into a history ring.
// ----------------------------------------------------------------------------
// Each transaction on the in_ channel is one tick: a start request, an
// optional compressed byte and its end-of-stream mark (tlast). Each tick
// gives exactly one transaction on the out_ channel, in order, telling
// whether the byte was consumed, the decompressed byte if any, and the
// finished and error status. A tick can be taken every cycle while the queue
// is not full; results pass the queue, the read stage and the output register.
// The front parses headers and tracks counts, a four-entry queue decouples
// it from the back end, which reads the history memory (one read, one
// write port, registered read data) and holds the result register.
// When out_tready is low, results collect in the queue and in_tready falls
// once it is full. Reset empties the pipeline and clears the stream state
// and output_limit; the history memory is not cleared, as no entry is
// read before it is written. The user sets output_limit through the cfg_
// port only while no tick is outstanding; the block does not enforce this.
// ----------------------------------------------------------------------------
module lz_backref_decompressor #(
  parameter int HISTORY_DEPTH = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // start_req, byte_valid, in_byte[7:0], zero pad
  input  logic        in_tlast,   // in_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // consumed, out_valid, out_byte[7:0], finished,
                                  // error_code[1:0], zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int RW   = $bits(lzbd_pkg::res_t);
  localparam int QW   = RW + 2 * AW;

  logic [31:0]    limit_r;
  logic           acc, full, pop, head_valid;
  lzbd_pkg::res_t res, head_res;
  logic [AW-1:0]  raddr, waddr, head_raddr, head_waddr;
  logic [QW-1:0]  head_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'h0 : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      limit_r <= cfg_pwdata;
    end
  end

  assign in_tready = !full;
  assign acc       = in_tvalid && !full;

  lzbd_front #(.HISTORY_DEPTH(HISTORY_DEPTH), .AW(AW)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc),
    .start_req(in_tdata[0]), .byte_valid(in_tdata[1]), .in_byte(in_tdata[9:2]),
    .in_last(in_tlast), .output_limit(limit_r),
    .res(res), .raddr(raddr), .waddr(waddr)
  );

  lzbd_fifo #(.W(QW), .DEPTH(4)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(acc), .push_data({res, raddr, waddr}),
    .full(full), .pop(pop), .head_valid(head_valid), .head_data(head_data)
  );

  assign head_res   = head_data[QW-1:2*AW];
  assign head_raddr = head_data[2*AW-1:AW];
  assign head_waddr = head_data[AW-1:0];

  lzbd_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .AW(AW)) u_back (
    .clk(clk), .rst_n(rst_n), .head_valid(head_valid), .head_res(head_res),
    .head_raddr(head_raddr), .head_waddr(head_waddr), .pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule

### src/lzbd_checker.sv
// ----------------------------------------------------------------------------
// lzbd_checker
// Port-level checks on the decompressor's result stream.
// ----------------------------------------------------------------------------
module lzbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  // A held transaction keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  a_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[9:2] == 8'h00)
    else $error("byte present without out_valid");

  // Finished and failed exclude each other.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> out_tdata[12:11] == 2'd0)
    else $error("finished together with an error");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result presented straight after reset");

endmodule

bind lz_backref_decompressor lzbd_checker u_lzbd_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);

### bench/tb_lz_backref_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lz_backref_decompressor
// Drives compressed-stream ticks into the decompressor, predicts every result
// transaction with a behavioural decoder and compares them field by field.
// ----------------------------------------------------------------------------
module tb_lz_backref_decompressor;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  localparam int HIST = 8192;
  localparam logic [2:0] ADDR_OUTPUT_LIMIT = 3'd0;

  lz_backref_decompressor u_top (.*);

  always #2 clk = ~clk;

  // Decoder model state.
  logic [31:0]       m_limit;
  logic [7:0]        m_hist [HIST];
  logic [31:0]       m_written;
  lzbd_pkg::phase_t  m_phase;
  logic [7:0]        m_ctl;
  logic [31:0]       m_ext;
  logic [2:0]        m_ext_left;
  logic [32:0]       m_run;
  logic [13:0]       m_dist;
  logic              m_ended;
  logic              m_done;
  logic [1:0]        m_err;

  logic [12:0] expected_ticks [$];
  int          failures = 0;
  int          idle_cycles = 0;
  bit          burst_idle = 1'b1;
  int          hold_off = 0;

  function automatic logic [32:0] room();
    return (m_limit > m_written) ? {1'b0, m_limit - m_written} : 33'd0;
  endfunction

  function automatic void finish_op();
    m_phase = lzbd_pkg::PH_CTL;
    if (m_written >= m_limit || m_ended) m_done = 1'b1;
  endfunction

  function automatic void open_literal(logic [32:0] cnt);
    m_run = (cnt < room()) ? cnt : room();
    if (m_run == 0) finish_op();
    else if (m_ended) m_err = lzbd_pkg::ERR_LIT_END;
    else m_phase = lzbd_pkg::PH_LIT_RUN;
  endfunction

  function automatic void open_copy(logic [32:0] cnt, logic [31:0] ofs);
    logic [31:0] d;
    d = {19'd0, ofs[12:0]} + 32'd1;
    m_dist = d[13:0];
    cnt = cnt + 33'd3;
    if (d > m_written) begin
      m_err = lzbd_pkg::ERR_REF_PRE;
      return;
    end
    m_run = (cnt < room()) ? cnt : room();
    if (m_run == 0) finish_op();
    else m_phase = lzbd_pkg::PH_COPY;
  endfunction

  function automatic void emit(logic [7:0] b, ref logic ov, ref logic [7:0] ob);
    m_hist[m_written % HIST] = b;
    m_written++;
    m_run--;
    ov = 1'b1;
    ob = b;
  endfunction

  // Returns {err, finished, out_byte, out_valid, consumed}, as on out_tdata.
  function automatic logic [12:0] decode_tick(logic st, logic v, logic [7:0] b, logic l);
    logic cons, ov;
    logic [7:0] ob;
    logic [32:0] c;
    cons = 0; ov = 0; ob = 0;
    if (st) begin
      m_written = 0; m_phase = lzbd_pkg::PH_CTL; m_ctl = 0; m_ext = 0; m_ext_left = 0;
      m_run = 0; m_dist = 0; m_ended = 0; m_done = 0; m_err = lzbd_pkg::ERR_NONE;
    end
    if (!m_done && m_err == lzbd_pkg::ERR_NONE && m_written >= m_limit) m_done = 1;
    if (!m_done && m_err == lzbd_pkg::ERR_NONE) begin
      if (m_phase == lzbd_pkg::PH_COPY) begin
        emit(m_hist[(m_written - {18'd0, m_dist}) % HIST], ov, ob);
        if (m_run == 0) finish_op();
      end else if (m_phase == lzbd_pkg::PH_LIT_RUN) begin
        if (v) begin
          cons = 1;
          emit(b, ov, ob);
          if (l) m_ended = 1;
          if (m_run == 0) finish_op();
          else if (l) m_err = lzbd_pkg::ERR_LIT_END;
        end
      end else if (v) begin
        cons = 1;
        if (l) m_ended = 1;
        case (m_phase)
          lzbd_pkg::PH_CTL: begin
            m_ctl = b;
            if (b < lzbd_pkg::CTL_EXT1) open_literal({25'd0, b} + 33'd1);
            else if (b < lzbd_pkg::CTL_LIT_LIM) begin
              m_ext = 0;
              m_ext_left = (b == lzbd_pkg::CTL_EXT1) ? 3'd1 :
                           (b == lzbd_pkg::CTL_EXT2) ? 3'd2 : 3'd4;
              m_phase = lzbd_pkg::PH_LIT_EXT;
            end else if (!b[7] && b[6:5] == 2'b01) open_copy({31'd0, b[1:0]}, {29'd0, b[4:2]});
            else m_phase = lzbd_pkg::PH_REF_OFS;
          end
          lzbd_pkg::PH_LIT_EXT: begin
            m_ext = {m_ext[23:0], b};
            m_ext_left--;
            if (m_ext_left == 0) begin
              c = {1'b0, m_ext};
              if (m_ctl == lzbd_pkg::CTL_EXT1) c += lzbd_pkg::BIAS_EXT1;
              else if (m_ctl == lzbd_pkg::CTL_EXT2) c += lzbd_pkg::BIAS_EXT2;
              open_literal(c);
            end
          end
          lzbd_pkg::PH_REF_OFS: begin
            if (m_ctl[7]) open_copy({31'd0, m_ctl[6:5]}, {19'd0, m_ctl[4:0], b});
            else if (m_ctl[6:5] == 2'b10) open_copy({28'd0, m_ctl[4:0]} + 33'd4, {24'd0, b});
            else begin
              m_dist = {1'b0, m_ctl[4:0], b};
              m_phase = lzbd_pkg::PH_REF_CTL2;
            end
          end
          lzbd_pkg::PH_REF_CTL2: begin
            if (b == lzbd_pkg::REF_EXT2 || b == lzbd_pkg::REF_EXT4) begin
              m_ctl = b; m_ext = 0;
              m_ext_left = (b == lzbd_pkg::REF_EXT2) ? 3'd2 : 3'd4;
              m_phase = lzbd_pkg::PH_REF_EXT;
            end else open_copy({25'd0, b} + 33'd4, {18'd0, m_dist});
          end
          lzbd_pkg::PH_REF_EXT: begin
            m_ext = {m_ext[23:0], b};
            m_ext_left--;
            if (m_ext_left == 0) begin
              c = {1'b0, m_ext};
              if (m_ctl == lzbd_pkg::REF_EXT2) c += lzbd_pkg::BIAS_REF2;
              open_copy(c, {18'd0, m_dist});
            end
          end
          default: m_phase = lzbd_pkg::PH_CTL;
        endcase
        if (m_err == lzbd_pkg::ERR_NONE && !m_done && l &&
            (m_phase == lzbd_pkg::PH_LIT_EXT || m_phase == lzbd_pkg::PH_REF_OFS ||
             m_phase == lzbd_pkg::PH_REF_CTL2 || m_phase == lzbd_pkg::PH_REF_EXT))
          m_err = lzbd_pkg::ERR_CTL_END;
      end
    end
    return {m_err, m_done, ob, ov, cons};
  endfunction

  // Sends one tick; the prediction is made when the transaction is accepted.
  task automatic send_tick(logic st, logic v, logic [7:0] b, logic l);
    if (burst_idle && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, b, v, st};
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    expected_ticks.insert(expected_ticks.size(), decode_tick(st, v, b, l));
    @(negedge clk);
  endtask

  task automatic send_stream(input logic [7:0] bytes [$]);
    foreach (bytes[i]) send_tick(i == 0, 1'b1, bytes[i], i == bytes.size() - 1);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_limit(logic [31:0] value);
    drain();
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= ADDR_OUTPUT_LIMIT; cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    m_limit = value;
  endtask

  // Builds literal runs and back-references; some may reach before the start.
  task automatic random_stream(int ops, bit tail_noise);
    logic [7:0] s [$];
    int produced, n, d, form, x;
    produced = 0;
    for (int k = 0; k < ops; k++) begin
      if (produced == 0 || $urandom_range(0, 2) == 0) begin
        n = $urandom_range(0, 9);
        case ($urandom_range(0, 11))
          0: begin
            x = $urandom_range(0, 3);
            s.insert(s.size(), lzbd_pkg::CTL_EXT1); s.insert(s.size(), 8'(x));
            n = 30 + x;
          end
          1: begin
            x = $urandom_range(0, 2);
            s.insert(s.size(), lzbd_pkg::CTL_EXT2); s.insert(s.size(), 8'd0);
            s.insert(s.size(), 8'(x));
            n = 286 + x;
          end
          default: begin s.insert(s.size(), 8'(n)); n = n + 1; end
        endcase
        repeat (n) s.insert(s.size(), 8'($urandom));
        produced += n;
      end else begin
        d = $urandom_range(0, (produced > 8191 ? 8191 : produced - 1));
        if ($urandom_range(0, 15) == 0) d = $urandom_range(0, 8191);
        form = $urandom_range(0, 3);
        if (form == 1 && d > 7) form = 0;
        if (form == 2 && d > 255) form = 0;
        case (form)
          0: begin
            s.insert(s.size(), 8'h80 | 8'($urandom_range(0, 3) << 5) | 8'(d >> 8));
            s.insert(s.size(), 8'(d));
            produced += 3;
          end
          1: begin
            s.insert(s.size(), 8'h20 | 8'(d << 2) | 8'($urandom_range(0, 3)));
            produced += 3;
          end
          2: begin
            s.insert(s.size(), 8'h40 | 8'($urandom_range(0, 31)));
            s.insert(s.size(), 8'(d));
            produced += 7;
          end
          default: begin
            s.insert(s.size(), 8'h60 | 8'(d >> 8)); s.insert(s.size(), 8'(d));
            case ($urandom_range(0, 5))
              0: begin
                s.insert(s.size(), lzbd_pkg::REF_EXT2); s.insert(s.size(), 8'd0);
                s.insert(s.size(), 8'($urandom));
              end
              1: begin
                s.insert(s.size(), lzbd_pkg::REF_EXT4);
                repeat (3) s.insert(s.size(), 8'd0);
                s.insert(s.size(), 8'($urandom_range(0, 40)));
              end
              default: s.insert(s.size(), 8'($urandom_range(0, 253)));
            endcase
            produced += 7;
          end
        endcase
      end
    end
    if (tail_noise) s.insert(s.size(), 8'($urandom));
    send_stream(s);
    // Idle ticks let a pending copy run out; some carry no byte at all.
    repeat ($urandom_range(0, 3))
      send_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom), 1'b0);
  endtask

  task automatic test_literals();
    logic [7:0] s [$];
    write_limit(32'hFFFF_FFFF);
    s = {8'h00, 8'hFF, 8'h1C};
    repeat (29) s.insert(s.size(), 8'($urandom));
    s.insert(s.size(), 8'h20); // short back-reference, distance 1, count 3
    // Extended run of 256 bytes that the end of the stream leaves open.
    s.insert(s.size(), 8'h1D); s.insert(s.size(), 8'hE2);
    s.insert(s.size(), 8'h01); s.insert(s.size(), 8'h55);
    send_stream(s);
  endtask

  task automatic test_errors();
    send_stream('{8'h1F, 8'h00});                      // ends inside a header
    send_stream('{8'h05, 8'h12, 8'h34});               // ends inside a literal run
    send_stream('{8'h00, 8'hAA, 8'hBF, 8'hFF});        // reference before the start
    send_stream('{8'h02, 8'h01, 8'h02, 8'h03, 8'h60, 8'h02, 8'hFE, 8'h00, 8'h01});
    send_stream('{8'h00, 8'h7E, 8'h7F, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h02});
    send_stream('{8'h03, 8'h01, 8'h02, 8'h03, 8'h04, 8'h43, 8'h03, 8'h00, 8'h11});
  endtask

  task automatic test_limits();
    write_limit(32'd0);
    send_stream('{8'h00, 8'h11});
    write_limit(32'd5);
    send_stream('{8'h00, 8'h9C, 8'hA3, 8'h00});
    repeat (8) send_tick(1'b0, 1'b1, 8'h00, 1'b0);
    write_limit(32'd40);
    random_stream(6, 1'b1);
  endtask

  task automatic test_backpressure();
    write_limit(32'hFFFF_FFFF);
    hold_off = 60;
    send_stream('{8'h00, 8'h3C, 8'h40 | 8'd20, 8'h00, 8'h0F});
    repeat (20) send_tick(1'b0, 1'b0, 8'h00, 1'b0);
  endtask

  task automatic test_random();
    for (int k = 0; k < 24; k++) begin
      if (k % 8 == 0) write_limit($urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 300))
                                                             : 32'hFFFF_FFFF);
      if (k == 20) burst_idle = 1'b0;
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 6))
          send_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), 8'($urandom),
                    1'($urandom_range(0, 1)));
      else random_stream($urandom_range(2, 6), $urandom_range(0, 9) == 0);
    end
  endtask

  // Receiver: random stalls, and a long hold-off when asked.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (idle_cycles > 0) begin
      idle_cycles <= idle_cycles - 1;
      out_tready <= 1'b0;
    end else if (burst_idle && rst_n && $urandom_range(0, 9) == 0) begin
      idle_cycles <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  int quiet = 0;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_ticks.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        failures++;
      end else begin
        logic [12:0] e;
        e = expected_ticks.pop_front();
        if (out_tdata[0] !== e[0])
          $display("%0t: consumed exp %b got %b", $time, e[0], out_tdata[0]);
        if (out_tdata[1] !== e[1])
          $display("%0t: out_valid exp %b got %b", $time, e[1], out_tdata[1]);
        if (out_tdata[9:2] !== e[9:2])
          $display("%0t: out_byte exp %h got %h", $time, e[9:2], out_tdata[9:2]);
        if (out_tdata[10] !== e[10])
          $display("%0t: finished exp %b got %b", $time, e[10], out_tdata[10]);
        if (out_tdata[12:11] !== e[12:11])
          $display("%0t: error_code exp %0d got %0d", $time, e[12:11], out_tdata[12:11]);
        if (out_tdata[12:0] !== e) failures++;
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel || !rst_n ||
        hold_off > 0) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 2000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    m_limit = 0;
    void'(decode_tick(1'b1, 1'b0, 8'd0, 1'b0));
    expected_ticks.delete();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_literals();
    test_errors();
    test_limits();
    test_backpressure();
    test_random();
    drain();
    if (failures == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

### sim.f
src/lzbd_pkg.sv
src/lzbd_fifo.sv
src/lzbd_front.sv
src/lzbd_back.sv
src/lz_backref_decompressor.sv
src/lzbd_checker.sv
bench/tb_lz_backref_decompressor.sv
